[src/hbfd_pkg.sv]
// Shared constants and helpers for the HTTP body framing decoder.
package hbfd_pkg;

    localparam int unsigned COUNT_BITS = 32;
    localparam int unsigned ACC_BITS   = 33;
    localparam int unsigned BYTE_BITS  = 8;
    localparam int unsigned WORD_BITS  = 32;
    localparam int unsigned ADDR_BITS  = 4;
    localparam int unsigned OUT_BITS   = 48;

    localparam logic [WORD_BITS-1:0] BODY_LIMIT_RST = 32'd1048576;

    localparam logic [1:0] REG_BODY_MODE = 2'd0;
    localparam logic [1:0] REG_DECL_LEN  = 2'd1;
    localparam logic [1:0] REG_LIMIT     = 2'd2;

    localparam logic [1:0] MODE_NONE    = 2'd0;
    localparam logic [1:0] MODE_LENGTH  = 2'd1;
    localparam logic [1:0] MODE_CHUNKED = 2'd2;

    localparam logic [1:0] KIND_FRAMING = 2'd0;
    localparam logic [1:0] KIND_BODY    = 2'd1;
    localparam logic [1:0] KIND_LEFT    = 2'd2;
    localparam logic [1:0] KIND_REJECT  = 2'd3;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_BAD_REQ   = 2'd1;
    localparam logic [1:0] ERR_TOO_LARGE = 2'd2;

    localparam logic [BYTE_BITS-1:0] CH_CR    = 8'h0D;
    localparam logic [BYTE_BITS-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_BITS-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_BITS-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_BITS-1:0] CH_TAB   = 8'h09;

    // bit 4: valid hex digit, bits 3:0: digit value
    function automatic logic [4:0] hex_decode(input logic [BYTE_BITS-1:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

endpackage

[src/http_body_framing_decoder_unit.sv]
// HTTP message body framing decoder: content-length and chunked transfer coding.
//
//  channel  | direction | tdata                                        | tuser
//  s_       | in        | [7:0] data_byte                              | -
//  m_       | out       | [7:0] body_byte [9:8] error_code [10] complete| [1:0] result_kind
//           |           | [42:11] body_count, rest zero                 |
//  apb      | in/out    | 0x0 body_mode, 0x4 declared_length, 0x8 body_limit
//
// One word per cycle unless m_tready stalls; each word is decoded in the cycle it is taken
// and its result sits in the output register on the next cycle.
// s_tready is high whenever the output register is empty or being emptied.
// A stall on m_tready holds the result and blocks s_ only until it is taken.
// Reset clears all state to no-body mode with body_limit at 1 MiB.
module http_body_framing_decoder_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] data_byte
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [hbfd_pkg::OUT_BITS-1:0]  m_tdata,   // body_byte, error_code, complete, body_count
    output logic [1:0]                     m_tuser,   // [1:0] result_kind
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [hbfd_pkg::ADDR_BITS-1:0] paddr,
    input  logic [hbfd_pkg::WORD_BITS-1:0] pwdata,
    output logic [hbfd_pkg::WORD_BITS-1:0] prdata,
    output logic                           pready
);
    import hbfd_pkg::*;

    typedef enum logic [2:0] {
        PH_DONE, PH_LEN, PH_SIZE, PH_DATA, PH_DCR, PH_DLF, PH_TRAIL
    } phase_t;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [ACC_BITS-1:0]   ACC_SAT   = {1'b1, {(ACC_BITS-1){1'b0}}};

    logic [1:0]            mode_reg;
    logic [WORD_BITS-1:0]  len_reg;
    logic [WORD_BITS-1:0]  limit_reg;

    phase_t                phase_reg, phase_next;
    logic                  pcr_reg, pcr_next;
    logic [ACC_BITS-1:0]   acc_reg, acc_next;
    logic                  has_reg, has_next;
    logic                  bad_reg, bad_next;
    logic                  ovf_reg, ovf_next;
    logic [WORD_BITS-1:0]  rem_reg, rem_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;
    logic                  tcol_reg, tcol_next;
    logic                  tblk_reg, tblk_next;
    logic                  tbad_reg, tbad_next;
    logic [1:0]            err_reg, err_next;
    logic [1:0]            kind_next;

    logic                  out_valid_reg;
    logic [1:0]            out_kind_reg;
    logic [BYTE_BITS-1:0]  out_byte_reg;
    logic [1:0]            out_err_reg;
    logic                  out_done_reg;
    logic [COUNT_BITS-1:0] out_cnt_reg;

    logic                  in_acc;
    logic                  cfg_wr;
    logic                  cfg_arm;
    logic [1:0]            arm_mode;
    logic [WORD_BITS-1:0]  arm_len;
    logic                  body_phase;

    assign pready   = 1'b1;
    assign s_tready = !out_valid_reg || m_tready;
    assign in_acc   = s_tvalid && s_tready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign cfg_arm  = cfg_wr && (paddr[3:2] == REG_BODY_MODE || paddr[3:2] == REG_DECL_LEN);
    assign arm_mode = (paddr[3:2] == REG_BODY_MODE) ? pwdata[1:0] : mode_reg;
    assign arm_len  = (paddr[3:2] == REG_DECL_LEN)  ? pwdata : len_reg;
    assign body_phase = (phase_reg == PH_LEN) || (phase_reg == PH_DATA);

    always_comb begin
        case (paddr[3:2])
            REG_BODY_MODE: prdata = {{(WORD_BITS-2){1'b0}}, mode_reg};
            REG_DECL_LEN:  prdata = len_reg;
            REG_LIMIT:     prdata = limit_reg;
            default:       prdata = '0;
        endcase
    end

    always_comb begin
        logic [BYTE_BITS-1:0]  c;
        logic [4:0]            hx;
        logic                  line_clr;
        logic                  eat_char;
        logic [ACC_BITS+1-1:0] total;

        c         = s_tdata;
        hx        = hex_decode(c);
        line_clr  = 1'b0;
        eat_char  = 1'b0;
        total     = {1'b0, acc_reg} + {{(ACC_BITS+1-COUNT_BITS){1'b0}}, cnt_reg};

        phase_next = phase_reg;
        pcr_next   = pcr_reg;
        acc_next   = acc_reg;
        has_next   = has_reg;
        bad_next   = bad_reg;
        ovf_next   = ovf_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        tcol_next  = tcol_reg;
        tblk_next  = tblk_reg;
        tbad_next  = tbad_reg;
        err_next   = err_reg;
        kind_next  = KIND_FRAMING;

        if (err_reg != ERR_NONE) begin
            kind_next = KIND_REJECT;
        end else begin
            case (phase_reg)
                PH_LEN, PH_DATA: begin
                    kind_next = KIND_BODY;
                    if (cnt_reg != COUNT_MAX) begin
                        cnt_next = cnt_reg + COUNT_BITS'(1);
                    end
                    rem_next = rem_reg - WORD_BITS'(1);
                    if (rem_reg == 32'd1) begin
                        phase_next = (phase_reg == PH_LEN) ? PH_DONE : PH_DCR;
                    end
                end
                PH_DCR: begin
                    if (c != CH_CR) begin
                        err_next  = ERR_BAD_REQ;
                        kind_next = KIND_REJECT;
                    end else begin
                        phase_next = PH_DLF;
                    end
                end
                PH_DLF: begin
                    if (c != CH_LF) begin
                        err_next  = ERR_BAD_REQ;
                        kind_next = KIND_REJECT;
                    end else begin
                        phase_next = PH_SIZE;
                        line_clr   = 1'b1;
                    end
                end
                PH_SIZE, PH_TRAIL: begin
                    if (pcr_reg && c == CH_LF) begin
                        pcr_next = 1'b0;
                        if (!has_reg) begin
                            line_clr = 1'b1;
                            if (phase_reg == PH_TRAIL) begin
                                phase_next = PH_DONE;
                            end
                        end else if (phase_reg == PH_SIZE) begin
                            if (bad_reg) begin
                                err_next  = ERR_BAD_REQ;
                                kind_next = KIND_REJECT;
                            end else if (acc_reg > {1'b0, limit_reg} ||
                                         total > {2'b00, limit_reg}) begin
                                err_next  = ERR_TOO_LARGE;
                                kind_next = KIND_REJECT;
                            end else begin
                                line_clr = 1'b1;
                                if (acc_reg == '0) begin
                                    phase_next = PH_TRAIL;
                                end else begin
                                    rem_next   = acc_reg[WORD_BITS-1:0];
                                    phase_next = PH_DATA;
                                end
                            end
                        end else begin
                            if (!tcol_reg || tbad_reg) begin
                                err_next  = ERR_BAD_REQ;
                                kind_next = KIND_REJECT;
                            end else begin
                                line_clr = 1'b1;
                            end
                        end
                    end else begin
                        // a lone CR counts as an ordinary line character
                        if (pcr_reg) begin
                            has_next = 1'b1;
                            if (phase_reg == PH_SIZE) begin
                                bad_next = 1'b1;
                            end else begin
                                tblk_next = 1'b0;
                            end
                        end
                        pcr_next = (c == CH_CR);
                        eat_char = (c != CH_CR);
                    end
                end
                default: begin
                    kind_next = KIND_LEFT;
                end
            endcase
        end

        if (eat_char) begin
            has_next = 1'b1;
            if (phase_reg == PH_SIZE) begin
                if (!hx[4]) begin
                    bad_next = 1'b1;
                end else if (!ovf_reg) begin
                    if (acc_reg[ACC_BITS-1:ACC_BITS-5] != '0) begin
                        acc_next = ACC_SAT;
                        ovf_next = 1'b1;
                    end else begin
                        acc_next = {acc_reg[ACC_BITS-5:0], hx[3:0]};
                    end
                end
            end else begin
                if (c == CH_COLON && !tcol_reg) begin
                    tcol_next = 1'b1;
                    if (pcr_reg ? 1'b0 : tblk_reg) begin
                        tbad_next = 1'b1;
                    end
                end
                tblk_next = (c == CH_SPACE || c == CH_TAB);
            end
        end

        if (line_clr) begin
            pcr_next  = 1'b0;
            acc_next  = '0;
            has_next  = 1'b0;
            bad_next  = 1'b0;
            ovf_next  = 1'b0;
            tcol_next = 1'b0;
            tblk_next = 1'b0;
            tbad_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_NONE;
            len_reg       <= '0;
            limit_reg     <= BODY_LIMIT_RST;
            phase_reg     <= PH_DONE;
            pcr_reg       <= 1'b0;
            acc_reg       <= '0;
            has_reg       <= 1'b0;
            bad_reg       <= 1'b0;
            ovf_reg       <= 1'b0;
            rem_reg       <= '0;
            cnt_reg       <= '0;
            tcol_reg      <= 1'b0;
            tblk_reg      <= 1'b0;
            tbad_reg      <= 1'b0;
            err_reg       <= ERR_NONE;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (paddr[3:2])
                    REG_BODY_MODE: mode_reg  <= pwdata[1:0];
                    REG_DECL_LEN:  len_reg   <= pwdata;
                    REG_LIMIT:     limit_reg <= pwdata;
                    default:       ;
                endcase
            end
            if (cfg_arm) begin
                pcr_reg  <= 1'b0;
                acc_reg  <= '0;
                has_reg  <= 1'b0;
                bad_reg  <= 1'b0;
                ovf_reg  <= 1'b0;
                tcol_reg <= 1'b0;
                tblk_reg <= 1'b0;
                tbad_reg <= 1'b0;
                cnt_reg  <= '0;
                err_reg  <= ERR_NONE;
                rem_reg  <= '0;
                phase_reg <= PH_DONE;
                if (arm_mode == MODE_LENGTH) begin
                    rem_reg <= arm_len;
                    if (arm_len != '0) begin
                        phase_reg <= PH_LEN;
                    end
                end else if (arm_mode == MODE_CHUNKED) begin
                    phase_reg <= PH_SIZE;
                end
            end else if (in_acc) begin
                phase_reg <= phase_next;
                pcr_reg   <= pcr_next;
                acc_reg   <= acc_next;
                has_reg   <= has_next;
                bad_reg   <= bad_next;
                ovf_reg   <= ovf_next;
                rem_reg   <= rem_next;
                cnt_reg   <= cnt_next;
                tcol_reg  <= tcol_next;
                tblk_reg  <= tblk_next;
                tbad_reg  <= tbad_next;
                err_reg   <= err_next;
            end
            if (in_acc) begin
                out_valid_reg <= 1'b1;
                out_kind_reg  <= kind_next;
                out_byte_reg  <= s_tdata;
                out_err_reg   <= err_next;
                out_done_reg  <= (phase_next == PH_DONE) && (err_next == ERR_NONE);
                out_cnt_reg   <= cnt_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {{(OUT_BITS-BYTE_BITS-3-WORD_BITS){1'b0}},
                       out_cnt_reg[WORD_BITS-1:0], out_done_reg, out_err_reg, out_byte_reg};

    a_err_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (err_reg != ERR_NONE && !cfg_arm) |=> (err_reg == $past(err_reg)))
        else $error("latched error changed without re-arming");

    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && !cfg_arm && body_phase && err_reg == ERR_NONE && cnt_reg != COUNT_MAX)
        |=> (cnt_reg == $past(cnt_reg) + COUNT_BITS'(1)))
        else $error("body word did not advance the delivered count");

    a_reject_code: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_REJECT) |-> (m_tdata[9:8] != ERR_NONE))
        else $error("rejected word carries no error code");

    a_body_no_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && !cfg_arm && err_reg == ERR_NONE && phase_reg == PH_DATA)
        |=> (phase_reg == PH_DATA || phase_reg == PH_DCR))
        else $error("chunk data left for an unexpected phase");

endmodule

[dv/tb_http_body_framing_decoder_unit.sv]
// Self-checking testbench for the HTTP body framing decoder: stream, register and framing checks.
module tb_http_body_framing_decoder_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import hbfd_pkg::*;

    localparam logic [1:0] REG_SPARE  = 2'd3;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam logic [2:0] TF_COLON = 3'b001;
    localparam logic [2:0] TF_BLANK = 3'b010;
    localparam logic [2:0] TF_BAD   = 3'b100;

    typedef enum logic [2:0] {
        PH_DONE  = 3'd0,
        PH_LEN   = 3'd1,
        PH_SIZE  = 3'd2,
        PH_DATA  = 3'd3,
        PH_DCR   = 3'd4,
        PH_DLF   = 3'd5,
        PH_TRAIL = 3'd6
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic [1:0]  err;
        logic        done;
        logic [31:0] count;
    } decode_result_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;
    logic                 m_tvalid;
    logic                 m_tready = 1'b1;
    logic [OUT_BITS-1:0]  m_tdata;
    logic [1:0]           m_tuser;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_BITS-1:0] paddr;
    logic [WORD_BITS-1:0] pwdata;
    logic [WORD_BITS-1:0] prdata;
    logic                 pready;

    decode_result_t decoded_q[$];
    logic [7:0]     stream_q[$];

    int gap_pct    = 0;
    int stall_pct  = 0;
    int stall_left = 0;
    int words_sent = 0;
    int reg_writes = 0;
    int results_seen = 0;
    int mismatches = 0;

    // decoder state mirror
    logic [1:0]  mode_r;
    logic [31:0] length_r;
    logic [31:0] limit_r;
    phase_t      phase_r;
    logic        cr_pending;
    logic [32:0] size_acc;
    logic        line_content;
    logic        line_bad;
    logic        size_sat;
    logic [31:0] remaining;
    logic [31:0] delivered;
    logic [2:0]  tflags;
    logic [1:0]  err_r;

    http_body_framing_decoder_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 aclk = ~aclk;

    function automatic void clear_line();
        cr_pending   = 1'b0;
        size_acc     = '0;
        line_content = 1'b0;
        line_bad     = 1'b0;
        size_sat     = 1'b0;
        tflags       = '0;
    endfunction

    function automatic void rearm();
        clear_line();
        remaining = '0;
        delivered = '0;
        err_r     = ERR_NONE;
        case (mode_r)
            MODE_LENGTH: begin
                remaining = length_r;
                phase_r   = (length_r == '0) ? PH_DONE : PH_LEN;
            end
            MODE_CHUNKED: phase_r = PH_SIZE;
            default:      phase_r = PH_DONE;
        endcase
    endfunction

    function automatic void apply_register(input logic [1:0] idx, input logic [31:0] val);
        case (idx)
            REG_BODY_MODE: begin
                mode_r = val[1:0];
                rearm();
            end
            REG_DECL_LEN: begin
                length_r = val;
                rearm();
            end
            REG_LIMIT: limit_r = val;
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] register_value(input logic [1:0] idx);
        case (idx)
            REG_BODY_MODE: return {30'd0, mode_r};
            REG_DECL_LEN:  return length_r;
            REG_LIMIT:     return limit_r;
            default:       return '0;
        endcase
    endfunction

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
        if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
        if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
        return -1;
    endfunction

    function automatic void take_line_char(input logic [7:0] c);
        int d;
        logic [36:0] v;
        line_content = 1'b1;
        if (phase_r == PH_SIZE) begin
            d = hex_digit(c);
            if (d < 0) begin
                line_bad = 1'b1;
            end else if (!size_sat) begin
                v = {size_acc, 4'h0} + 37'(d);
                if (v >= 37'h1_0000_0000) begin
                    v        = 37'h1_0000_0000;
                    size_sat = 1'b1;
                end
                size_acc = v[32:0];
            end
        end else begin
            if (c == CH_COLON && (tflags & TF_COLON) == 3'b000) begin
                if ((tflags & TF_BLANK) != 3'b000) tflags |= TF_BAD;
                tflags |= TF_COLON;
            end
            if (c == CH_SPACE || c == CH_TAB) tflags |= TF_BLANK;
            else tflags &= ~TF_BLANK;
        end
    endfunction

    function automatic logic [1:0] finish_line();
        logic [33:0] total;
        if (phase_r == PH_SIZE) begin
            if (!line_content) begin
                clear_line();
                return KIND_FRAMING;
            end
            if (line_bad) begin
                err_r = ERR_BAD_REQ;
                return KIND_REJECT;
            end
            total = 34'(delivered) + 34'(size_acc);
            if (size_acc > 33'(limit_r) || total > 34'(limit_r)) begin
                err_r = ERR_TOO_LARGE;
                return KIND_REJECT;
            end
            if (size_acc == '0) begin
                phase_r = PH_TRAIL;
            end else begin
                remaining = size_acc[31:0];
                phase_r   = PH_DATA;
            end
            clear_line();
            return KIND_FRAMING;
        end
        if (!line_content) begin
            phase_r = PH_DONE;
            clear_line();
            return KIND_FRAMING;
        end
        if ((tflags & TF_COLON) == 3'b000 || (tflags & TF_BAD) != 3'b000) begin
            err_r = ERR_BAD_REQ;
            return KIND_REJECT;
        end
        clear_line();
        return KIND_FRAMING;
    endfunction

    function automatic logic [1:0] advance_phase(input logic [7:0] c);
        logic [1:0] k;
        k = KIND_FRAMING;
        case (phase_r)
            PH_LEN, PH_DATA: begin
                if (delivered != '1) delivered++;
                remaining--;
                if (remaining == '0) phase_r = (phase_r == PH_LEN) ? PH_DONE : PH_DCR;
                k = KIND_BODY;
            end
            PH_DCR: begin
                if (c != CH_CR) begin
                    err_r = ERR_BAD_REQ;
                    k     = KIND_REJECT;
                end else begin
                    phase_r = PH_DLF;
                end
            end
            PH_DLF: begin
                if (c != CH_LF) begin
                    err_r = ERR_BAD_REQ;
                    k     = KIND_REJECT;
                end else begin
                    phase_r = PH_SIZE;
                    clear_line();
                end
            end
            PH_SIZE, PH_TRAIL: begin
                if (cr_pending && c == CH_LF) begin
                    cr_pending = 1'b0;
                    k = finish_line();
                end else begin
                    if (cr_pending) take_line_char(CH_CR);
                    if (c == CH_CR) begin
                        cr_pending = 1'b1;
                    end else begin
                        cr_pending = 1'b0;
                        take_line_char(c);
                    end
                end
            end
            default: k = KIND_LEFT;
        endcase
        return k;
    endfunction

    function automatic decode_result_t decode_byte(input logic [7:0] c);
        decode_result_t r;
        r.kind  = (err_r != ERR_NONE) ? KIND_REJECT : advance_phase(c);
        r.data  = c;
        r.err   = err_r;
        r.done  = (phase_r == PH_DONE && err_r == ERR_NONE);
        r.count = delivered;
        return r;
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
        return $urandom_range(1, 3);
    endfunction

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready = 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            m_tready   = 1'b0;
            stall_left = pick_gap() - 1;
        end else begin
            m_tready = 1'b1;
        end
    end

    task automatic report_field(input string what, input logic [31:0] want_v,
                                input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t: %s expected %0h got %0h", $time, what, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : check_results
        decode_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (decoded_q.size() == 0) begin
                $display("%0t: unexpected word, expected none got tuser %0h tdata %0h",
                         $time, m_tuser, m_tdata);
                mismatches++;
            end else begin
                want = decoded_q.pop_front();
                results_seen++;
                report_field("result_kind", 32'(want.kind), 32'(m_tuser));
                report_field("body_byte", 32'(want.data), 32'(m_tdata[7:0]));
                report_field("error_code", 32'(want.err), 32'(m_tdata[9:8]));
                report_field("complete", 32'(want.done), 32'(m_tdata[10]));
                report_field("body_count", want.count, m_tdata[42:11]);
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        decode_result_t pred;
        @(negedge aclk);
        if ($urandom_range(0, 99) < gap_pct) begin
            s_tvalid = 1'b0;
            repeat (pick_gap()) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        do @(posedge aclk); while (!s_tready);
        pred      = decode_byte(b);
        decoded_q = {decoded_q, pred};
        words_sent++;
    endtask

    task automatic send_stream();
        while (stream_q.size() != 0) send_byte(stream_q.pop_front());
    endtask

    task automatic settle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (decoded_q.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] val);
        settle();
        @(negedge aclk);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        pwrite  = 1'b0;
        penable = 1'b0;
        apply_register(idx, val);
        reg_writes++;
        @(negedge aclk);
        penable = 1'b1;
        @(posedge aclk);
        report_field("register readback", register_value(idx), prdata);
        report_field("pready", 32'd1, 32'(pready));
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic queue_byte(input logic [7:0] b);
        stream_q = {stream_q, b};
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) queue_byte(s[i]);
    endtask

    task automatic push_crlf();
        queue_byte(CH_CR);
        queue_byte(CH_LF);
    endtask

    task automatic push_size(input int sz);
        string t;
        logic [7:0] c;
        t = $sformatf("%0h", sz);
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 2)) t = {"0", t};
        end
        for (int i = 0; i < t.len(); i++) begin
            c = t[i];
            if (c >= 8'h61 && c <= 8'h66 && $urandom_range(0, 1) == 1) c = c - 8'h20;
            queue_byte(c);
        end
        push_crlf();
    endtask

    task automatic push_trailer();
        repeat ($urandom_range(1, 4)) queue_byte(8'($urandom_range('h61, 'h7a)));
        case ($urandom_range(0, 7))
            0: ;
            1: begin
                queue_byte(CH_SPACE);
                queue_byte(CH_COLON);
            end
            default: queue_byte(CH_COLON);
        endcase
        repeat ($urandom_range(0, 5)) queue_byte(8'($urandom_range('h20, 'h7e)));
        push_crlf();
    endtask

    task automatic build_chunked_message();
        int sz;
        if ($urandom_range(0, 3) == 0) push_crlf();
        repeat ($urandom_range(1, 4)) begin
            sz = ($urandom_range(0, 7) == 0) ? $urandom_range(21, 48) : $urandom_range(1, 20);
            push_size(sz);
            repeat (sz) queue_byte(8'($urandom));
            push_crlf();
        end
        push_size(0);
        repeat ($urandom_range(0, 2)) push_trailer();
        push_crlf();
    endtask

    task automatic corrupt_stream();
        int pos;
        if (stream_q.size() == 0 || $urandom_range(0, 5) != 0) return;
        pos = $urandom_range(0, stream_q.size() - 1);
        if ($urandom_range(0, 1) == 0) stream_q[pos] = 8'($urandom);
        else stream_q.insert(pos, 8'($urandom));
    endtask

    task automatic rearm_chunked(input logic [31:0] lim);
        write_register(REG_LIMIT, lim);
        write_register(REG_BODY_MODE, 32'(MODE_CHUNKED));
    endtask

    task automatic test_no_body();
        stream_q = '{8'h00, 8'hFF};
        send_stream();
        write_register(REG_SPARE, 32'hFFFF_FFFF);
        write_register(REG_BODY_MODE, 32'(MODE_SPARE));
        stream_q = '{8'h55};
        send_stream();
    endtask

    task automatic test_content_length();
        write_register(REG_DECL_LEN, 32'd0);
        write_register(REG_BODY_MODE, 32'(MODE_LENGTH));
        stream_q = '{8'hA5};
        send_stream();
        write_register(REG_DECL_LEN, 32'd3);
        stream_q = '{8'h00, 8'hFF, 8'h0D, 8'h0A};
        send_stream();
        write_register(REG_DECL_LEN, 32'hFFFF_FFFF);
        stream_q = '{8'h12, 8'h34};
        send_stream();
    endtask

    task automatic test_chunked_framing();
        rearm_chunked(BODY_LIMIT_RST);
        push_crlf();
        push_text("A");
        push_crlf();
        queue_byte(8'h00);
        queue_byte(8'hFF);
        queue_byte(CH_CR);
        queue_byte(CH_LF);
        repeat (6) queue_byte(8'($urandom));
        push_crlf();
        push_text("0");
        push_crlf();
        push_text("Ab:");
        queue_byte(CH_TAB);
        push_text("1 ");
        push_crlf();
        push_crlf();
        push_text("z");
        send_stream();
        // size equal to the limit, then a few data words
        rearm_chunked(32'hFFFF_FFFF);
        push_text("FFFFFFFF");
        push_crlf();
        push_text("xy");
        send_stream();
        rearm_chunked(32'd0);
        push_text("0");
        push_crlf();
        push_crlf();
        push_text("q");
        send_stream();
    endtask

    task automatic test_chunked_errors();
        // lone CR inside a size line
        rearm_chunked(BODY_LIMIT_RST);
        push_text("5");
        queue_byte(CH_CR);
        push_crlf();
        push_text("z");
        send_stream();
        // lone LF
        rearm_chunked(BODY_LIMIT_RST);
        queue_byte(CH_LF);
        push_crlf();
        send_stream();
        rearm_chunked(BODY_LIMIT_RST);
        push_text("g");
        push_crlf();
        send_stream();
        // missing chunk terminator
        rearm_chunked(BODY_LIMIT_RST);
        push_text("1");
        push_crlf();
        push_text("ab");
        send_stream();
        // trailer without colon, then with blank before colon
        rearm_chunked(BODY_LIMIT_RST);
        push_text("0");
        push_crlf();
        push_text("ab");
        push_crlf();
        send_stream();
        rearm_chunked(BODY_LIMIT_RST);
        push_text("0");
        push_crlf();
        push_text("a :b");
        push_crlf();
        send_stream();
        // single chunk and running total over the limit
        rearm_chunked(32'd4);
        push_text("5");
        push_crlf();
        send_stream();
        rearm_chunked(32'd4);
        push_text("3");
        push_crlf();
        push_text("abc");
        push_crlf();
        push_text("2");
        push_crlf();
        send_stream();
        // saturating size accumulation
        rearm_chunked(32'hFFFF_FFFF);
        push_text("fffffffff");
        push_crlf();
        push_text("k");
        send_stream();
    endtask

    task automatic run_random_phase();
        int sel;
        int n;
        logic [31:0] lim;
        logic [31:0] len;
        case ($urandom_range(0, 2))
            0: gap_pct = 0;
            1: gap_pct = 15;
            default: gap_pct = 40;
        endcase
        case ($urandom_range(0, 2))
            0: stall_pct = 0;
            1: stall_pct = 15;
            default: stall_pct = 40;
        endcase
        case ($urandom_range(0, 5))
            0: lim = 32'd0;
            1: lim = $urandom_range(0, 120);
            2: lim = BODY_LIMIT_RST;
            3: lim = 32'hFFFF_FFFF;
            default: lim = $urandom;
        endcase
        write_register(REG_LIMIT, lim);
        sel = $urandom_range(0, 9);
        if (sel <= 5) begin
            write_register(REG_BODY_MODE, 32'(MODE_CHUNKED));
            build_chunked_message();
            corrupt_stream();
        end else if (sel <= 7) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 40);
            write_register(REG_DECL_LEN, len);
            write_register(REG_BODY_MODE, 32'(MODE_LENGTH));
            n = (len > 40) ? 30 : int'(len);
            repeat (n) queue_byte(8'($urandom));
        end else if (sel == 8) begin
            if ($urandom_range(0, 1) == 1) write_register(REG_DECL_LEN, $urandom);
            write_register(REG_BODY_MODE,
                           32'(($urandom_range(0, 1) == 1) ? MODE_NONE : MODE_SPARE));
        end else begin
            write_register(REG_BODY_MODE, 32'(MODE_CHUNKED));
            repeat ($urandom_range(10, 30)) begin
                case ($urandom_range(0, 5))
                    0: queue_byte(CH_CR);
                    1: queue_byte(CH_LF);
                    2: queue_byte(8'($urandom_range('h30, 'h39)));
                    3: queue_byte(8'($urandom_range('h61, 'h66)));
                    default: queue_byte(8'($urandom));
                endcase
            end
        end
        repeat ($urandom_range(0, 4)) queue_byte(8'($urandom));
        send_stream();
    endtask

    task automatic test_random_bodies();
        int start;
        start = words_sent;
        while (words_sent - start < 1600) run_random_phase();
    endtask

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        mode_r   = MODE_NONE;
        length_r = '0;
        limit_r  = BODY_LIMIT_RST;
        rearm();
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_no_body();
        test_content_length();
        test_chunked_framing();
        test_chunked_errors();
        test_random_bodies();

        settle();
        repeat (4) @(posedge aclk);
        $display("covered %0d words and %0d register writes", words_sent, reg_writes);
        $display("over no-body, length and chunked framing; checked %0d results, %0d mismatches",
                 results_seen, mismatches);
        if (mismatches == 0 && decoded_q.size() == 0) begin
            $display("tb_http_body_framing_decoder_unit OK");
        end else begin
            $display("tb_http_body_framing_decoder_unit NOT OK");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, decoded_q.size());
        $display("tb_http_body_framing_decoder_unit NOT OK");
        $finish;
    end

endmodule
